// ----- hdl/i2cseq_pkg.sv -----
// Package with the shared types and constants of the I2C byte sequencer.
`timescale 1ns / 1ps

package i2cseq_pkg;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_STOP  = 3'd4
   } op_type;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic [6:0] TargetAddressReset = 7'd72;

   // Bit index codes beyond the data bits: acknowledge phase and start condition.
   localparam logic [3:0] IdxAck = 4'd8;
   localparam logic [3:0] IdxPre = 4'd9;

   localparam logic [1:0] PhaseA = 2'd0;
   localparam logic [1:0] PhaseB = 2'd1;
   localparam logic [1:0] PhaseC = 2'd2;
   localparam logic [1:0] PhaseD = 2'd3;

endpackage

// ----- hdl/i2cseq_if.sv -----
// Valid/ready channel interfaces for the tick items and the pin step results.
`timescale 1ns / 1ps

interface i2cseq_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [7:0] data_byte;
   logic       read_direction;
   logic       last_read;
   logic       sda_in;

   modport source (output valid, operation, data_byte, read_direction, last_read, sda_in,
                   input ready);
   modport sink (input valid, operation, data_byte, read_direction, last_read, sda_in,
                 output ready);
endinterface

interface i2cseq_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic       nack_seen;
   logic [7:0] received_byte;
   logic       rejected;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, nack_seen,
                   received_byte, rejected, input ready);
   modport sink (input valid, scl_level, sda_level, busy_res, done_res, nack_seen,
                 received_byte, rejected, output ready);
endinterface

// ----- hdl/i2c_master_byte_sequencer.sv -----
// Top level of the single-master I2C byte sequencer.
//
//   channel   direction  handshake          contents
//   req_chan  in         valid/ready        operation, data_byte, read_direction,
//                                           last_read, sda_in
//   rsp_chan  out        valid/ready        scl_level, sda_level, busy_res, done_res,
//                                           nack_seen, received_byte, rejected
//   APB       in         psel/penable       target_address at byte address 0
//
// Each item passes through the input register and then the result register, and one item
// is accepted every cycle while the result is not stalled.
// The rate is set by the single pin step evaluated between the two registers.
// A stalled result holds the pipeline, and the input register keeps one item meanwhile.
// Synchronous reset idles the sequencer with both lines released.
`timescale 1ns / 1ps

module i2c_master_byte_sequencer
   import i2cseq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   i2cseq_req_if.sink              req_chan,
   i2cseq_rsp_if.source            rsp_chan,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   logic [6:0] target_address;

   i2cseq_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .target_address (target_address)
   );

   i2cseq_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .target_address (target_address),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan)
   );

endmodule

// ----- hdl/i2cseq_csr.sv -----
// APB register block holding the target address.
`timescale 1ns / 1ps

module i2cseq_csr
   import i2cseq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready,
   output logic [6:0]              target_address
);

   logic [6:0] target_address_ff;
   logic [6:0] target_address_in;
   logic       addr_hit;

   assign addr_hit = (paddr[CsrAddrWidth-1:2] == '0);
   assign pready = 1'b1;

   always_comb begin
      target_address_in = target_address_ff;
      if (psel && penable && pwrite && addr_hit) begin
         target_address_in = pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_address_ff <= TargetAddressReset;
      end else begin
         target_address_ff <= target_address_in;
      end
   end

   assign prdata = addr_hit ? {{(CsrDataWidth-7){1'b0}}, target_address_ff} : '0;
   assign target_address = target_address_ff;

endmodule

// ----- hdl/i2cseq_engine.sv -----
// Tick pipeline: input register, one pin step of the bus sequencer, result register.
`timescale 1ns / 1ps

module i2cseq_engine
   import i2cseq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [6:0] target_address,
   i2cseq_req_if.sink   req_chan,
   i2cseq_rsp_if.source rsp_chan
);

   // Input register.
   logic       in_valid_ff;
   logic [2:0] in_op_ff;
   logic [7:0] in_data_ff;
   logic       in_dir_ff;
   logic       in_last_ff;
   logic       in_sda_ff;
   logic       advance;

   // Sequencer state.
   op_type     cmd_ff, cmd_in;
   logic [1:0] phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] read_ff, read_in;
   logic       ack_ff, ack_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       nack_rd_ff, nack_rd_in;

   // Result register.
   logic       out_valid_ff;
   logic       out_done_ff;
   logic       out_rej_ff;
   logic       rej;
   logic       fin;
   logic       run;
   logic       op_ok;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_op_ff   <= req_chan.operation;
         in_data_ff <= req_chan.data_byte;
         in_dir_ff  <= req_chan.read_direction;
         in_last_ff <= req_chan.last_read;
         in_sda_ff  <= req_chan.sda_in;
      end
   end

   assign op_ok = (in_op_ff == OP_START) || (in_op_ff == OP_WRITE) ||
                  (in_op_ff == OP_READ) || (in_op_ff == OP_STOP);

   always_comb begin
      cmd_in     = cmd_ff;
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      read_in    = read_ff;
      ack_in     = ack_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      nack_rd_in = nack_rd_ff;
      rej        = 1'b0;
      fin        = 1'b0;
      run        = 1'b0;

      // A new command is loaded only while idle; its first step runs on the same tick.
      if (cmd_ff != OP_NONE) begin
         rej = op_ok;
         run = 1'b1;
      end else if (op_ok) begin
         run      = 1'b1;
         cmd_in   = op_type'(in_op_ff);
         phase_in = PhaseA;
         unique case (cmd_in)
            OP_START: begin
               bit_in   = IdxPre;
               shift_in = {target_address, in_dir_ff};
            end
            OP_WRITE: begin
               bit_in   = 4'd7;
               shift_in = in_data_ff;
            end
            OP_READ: begin
               bit_in     = 4'd7;
               shift_in   = 8'd0;
               nack_rd_in = in_last_ff;
            end
            default: begin
               bit_in = 4'd0;
            end
         endcase
      end

      if (run) begin
         priority if (cmd_in == OP_STOP) begin
            if (phase_in == PhaseA) begin
               scl_in   = 1'b1;
               phase_in = PhaseB;
            end else begin
               sda_in = 1'b1;
               fin    = 1'b1;
            end
         end else if (bit_in == IdxPre) begin
            if (phase_in == PhaseA) begin
               sda_in   = 1'b0;
               phase_in = PhaseB;
            end else begin
               scl_in   = 1'b0;
               bit_in   = 4'd7;
               phase_in = PhaseA;
            end
         end else if (bit_in <= 4'd7) begin
            if (phase_in == PhaseA) begin
               sda_in   = (cmd_in == OP_READ) ? 1'b1 : shift_in[bit_in[2:0]];
               phase_in = PhaseB;
            end else if (phase_in == PhaseB) begin
               scl_in = 1'b1;
               if (cmd_in == OP_READ) begin
                  shift_in[bit_in[2:0]] = shift_in[bit_in[2:0]] | in_sda_ff;
               end
               phase_in = PhaseC;
            end else begin
               scl_in   = 1'b0;
               bit_in   = (bit_in == 4'd0) ? IdxAck : bit_in - 4'd1;
               phase_in = PhaseA;
            end
         end else if (cmd_in == OP_READ) begin
            unique case (phase_in)
               PhaseA: begin
                  sda_in   = nack_rd_in;
                  phase_in = PhaseB;
               end
               PhaseB: begin
                  scl_in   = 1'b1;
                  phase_in = PhaseC;
               end
               PhaseC: begin
                  scl_in   = 1'b0;
                  phase_in = PhaseD;
               end
               default: begin
                  sda_in  = 1'b1;
                  read_in = shift_in;
                  fin     = 1'b1;
               end
            endcase
         end else begin
            priority if (phase_in == PhaseA) begin
               sda_in   = 1'b1;
               phase_in = PhaseB;
            end else if (phase_in == PhaseB) begin
               scl_in   = 1'b1;
               ack_in   = in_sda_ff;
               phase_in = PhaseC;
            end else if (phase_in == PhaseC && cmd_in == OP_WRITE) begin
               if (!ack_in) begin
                  sda_in = 1'b0;
               end
               phase_in = PhaseD;
            end else begin
               scl_in = 1'b0;
               fin    = 1'b1;
            end
         end

         if (fin) begin
            cmd_in   = OP_NONE;
            phase_in = PhaseA;
            bit_in   = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff     <= OP_NONE;
         phase_ff   <= PhaseA;
         bit_ff     <= 4'd0;
         shift_ff   <= 8'd0;
         read_ff    <= 8'd0;
         ack_ff     <= 1'b0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
         nack_rd_ff <= 1'b0;
      end else if (advance) begin
         cmd_ff     <= cmd_in;
         phase_ff   <= phase_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         read_ff    <= read_in;
         ack_ff     <= ack_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in;
         nack_rd_ff <= nack_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_done_ff <= fin;
         out_rej_ff  <= rej;
      end
   end

   // Pin levels, busy, acknowledge and received byte are read straight from the state.
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.scl_level     = scl_ff;
   assign rsp_chan.sda_level     = sda_ff;
   assign rsp_chan.busy_res      = (cmd_ff != OP_NONE);
   assign rsp_chan.done_res      = out_done_ff;
   assign rsp_chan.nack_seen     = ack_ff;
   assign rsp_chan.received_byte = read_ff;
   assign rsp_chan.rejected      = out_rej_ff;

   // An idle sequencer holds its counters at zero.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == OP_NONE) |-> (bit_ff == 4'd0 && phase_ff == PhaseA))
      else $error("idle sequencer with nonzero step counters");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= IdxPre)
      else $error("bit index out of range");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_done_ff) |-> (cmd_ff == OP_NONE))
      else $error("done reported while still busy");

   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("stepped item produced no result");

   a_stop_phase: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == OP_STOP) |-> (phase_ff == PhaseB))
      else $error("stop command in unexpected phase");

endmodule

// ----- verif/i2cseq_step_checker.sv -----
// Checker that predicts every pin step of the I2C byte sequencer and compares the results.
`timescale 1ns / 1ps

module i2cseq_step_checker
   import i2cseq_pkg::*;
#(
   parameter logic [CsrAddrWidth-1:0] TargetCsrOffset = '0
) (
   input  logic                    clock,
   input  logic                    reset,
   i2cseq_req_if                   req_mon,
   i2cseq_rsp_if                   rsp_mon,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic                    pready,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   input  logic [CsrDataWidth-1:0] prdata,
   output int unsigned             error_count,
   output int unsigned             outstanding_steps
);

   localparam logic [3:0] MsbIndex = 4'd7;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic       nack_seen;
      logic [7:0] received_byte;
      logic       rejected;
   } pin_step_type;

   logic [6:0]   model_target;
   op_type       cur_cmd;
   logic [1:0]   cur_phase;
   logic [3:0]   cur_bit;
   logic [7:0]   tx_shift;
   logic [7:0]   rx_hold;
   logic         ack_hold;
   logic         scl_drive;
   logic         sda_drive;
   logic         nack_pending;
   pin_step_type expected_steps[$];

   initial begin
      error_count = 0;
      outstanding_steps = 0;
   end

   function automatic logic advance_pins(input logic sda);
      logic fin;
      fin = 1'b0;
      if (cur_cmd == OP_STOP) begin
         if (cur_phase == PhaseA) begin
            scl_drive = 1'b1;
            cur_phase = PhaseB;
         end else begin
            sda_drive = 1'b1;
            fin = 1'b1;
         end
      end else if (cur_bit == IdxPre) begin
         if (cur_phase == PhaseA) begin
            sda_drive = 1'b0;
            cur_phase = PhaseB;
         end else begin
            scl_drive = 1'b0;
            cur_bit = MsbIndex;
            cur_phase = PhaseA;
         end
      end else if (cur_bit <= MsbIndex) begin
         case (cur_phase)
            PhaseA: begin
               sda_drive = (cur_cmd == OP_READ) ? 1'b1 : tx_shift[cur_bit[2:0]];
               cur_phase = PhaseB;
            end
            PhaseB: begin
               scl_drive = 1'b1;
               if (cur_cmd == OP_READ) tx_shift[cur_bit[2:0]] = tx_shift[cur_bit[2:0]] | sda;
               cur_phase = PhaseC;
            end
            default: begin
               scl_drive = 1'b0;
               cur_bit = (cur_bit == '0) ? IdxAck : cur_bit - 4'd1;
               cur_phase = PhaseA;
            end
         endcase
      end else if (cur_cmd == OP_READ) begin
         case (cur_phase)
            PhaseA: begin
               sda_drive = nack_pending;
               cur_phase = PhaseB;
            end
            PhaseB: begin
               scl_drive = 1'b1;
               cur_phase = PhaseC;
            end
            PhaseC: begin
               scl_drive = 1'b0;
               cur_phase = PhaseD;
            end
            default: begin
               sda_drive = 1'b1;
               rx_hold = tx_shift;
               fin = 1'b1;
            end
         endcase
      end else begin
         if (cur_phase == PhaseA) begin
            sda_drive = 1'b1;
            cur_phase = PhaseB;
         end else if (cur_phase == PhaseB) begin
            scl_drive = 1'b1;
            ack_hold = sda;
            cur_phase = PhaseC;
         end else if (cur_phase == PhaseC && cur_cmd == OP_WRITE) begin
            if (!ack_hold) sda_drive = 1'b0;
            cur_phase = PhaseD;
         end else begin
            scl_drive = 1'b0;
            fin = 1'b1;
         end
      end
      if (fin) begin
         cur_cmd = OP_NONE;
         cur_phase = PhaseA;
         cur_bit = '0;
      end
      return fin;
   endfunction

   function automatic pin_step_type predict_tick(input logic [2:0] op, input logic [7:0] data,
                                                 input logic dir, input logic last,
                                                 input logic sda);
      logic rej;
      logic fin;
      logic cmd_ok;
      rej = 1'b0;
      fin = 1'b0;
      cmd_ok = (op >= OP_START) && (op <= OP_STOP);
      if (cur_cmd != OP_NONE) begin
         rej = cmd_ok;
         fin = advance_pins(sda);
      end else if (cmd_ok) begin
         cur_cmd = op_type'(op);
         cur_phase = PhaseA;
         case (cur_cmd)
            OP_START: begin
               cur_bit = IdxPre;
               tx_shift = {model_target, dir};
            end
            OP_WRITE: begin
               cur_bit = MsbIndex;
               tx_shift = data;
            end
            OP_READ: begin
               cur_bit = MsbIndex;
               tx_shift = '0;
               nack_pending = last;
            end
            default: begin
               cur_bit = '0;
            end
         endcase
         fin = advance_pins(sda);
      end
      return '{scl_drive, sda_drive, cur_cmd != OP_NONE, fin, ack_hold, rx_hold, rej};
   endfunction

   function automatic int unsigned check_field(input string name, input logic [7:0] want,
                                               input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      pin_step_type got_step;
      pin_step_type want_step;
      if (reset) begin
         model_target = TargetAddressReset;
         cur_cmd = OP_NONE;
         cur_phase = PhaseA;
         cur_bit = '0;
         tx_shift = '0;
         rx_hold = '0;
         ack_hold = 1'b0;
         scl_drive = 1'b1;
         sda_drive = 1'b1;
         nack_pending = 1'b0;
         expected_steps.delete();
      end else begin
         if (psel && penable && pready && paddr == TargetCsrOffset) begin
            if (pwrite) begin
               model_target = pwdata[6:0];
            end else if (prdata[6:0] !== model_target) begin
               $display("%0t: target_address read expected %0h, got %0h",
                        $time, model_target, prdata[6:0]);
               error_count++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_steps.push_back(predict_tick(req_mon.operation, req_mon.data_byte,
                                                  req_mon.read_direction, req_mon.last_read,
                                                  req_mon.sda_in));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_step = '{rsp_mon.scl_level, rsp_mon.sda_level, rsp_mon.busy_res,
                         rsp_mon.done_res, rsp_mon.nack_seen, rsp_mon.received_byte,
                         rsp_mon.rejected};
            if (expected_steps.size() == 0) begin
               $display("%0t: unexpected pin step, expected none, got %0h", $time, got_step);
               error_count++;
            end else begin
               want_step = expected_steps.pop_front();
               error_count += check_field("scl_level", want_step.scl_level,
                                          got_step.scl_level);
               error_count += check_field("sda_level", want_step.sda_level,
                                          got_step.sda_level);
               error_count += check_field("busy_res", want_step.busy_res, got_step.busy_res);
               error_count += check_field("done_res", want_step.done_res, got_step.done_res);
               error_count += check_field("nack_seen", want_step.nack_seen,
                                          got_step.nack_seen);
               error_count += check_field("received_byte", want_step.received_byte,
                                          got_step.received_byte);
               error_count += check_field("rejected", want_step.rejected, got_step.rejected);
            end
         end
      end
      outstanding_steps = expected_steps.size();
   end

endmodule

// ----- verif/tb_i2c_master_byte_sequencer.sv -----
// Top of the I2C byte sequencer testbench: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps

module tb_i2c_master_byte_sequencer;
   import i2cseq_pkg::*;

   localparam logic [CsrAddrWidth-1:0] TargetCsrOffset = '0;
   localparam logic [CsrAddrWidth-1:0] SpareCsrOffset = 3'd4;
   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned PhaseItems = 260;
   localparam int unsigned StartTicks = 29;
   localparam int unsigned ByteTicks = 28;
   localparam int unsigned StopTicks = 2;
   localparam int unsigned DrainCycles = 4;

   logic                    clock;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;
   int unsigned             error_count;
   int unsigned             outstanding_steps;
   int unsigned             cycle_count;
   int unsigned             ticks_sent;
   int unsigned             send_idle_pct;
   int unsigned             stall_pct;

   i2cseq_req_if req_chan ();
   i2cseq_rsp_if rsp_chan ();

   i2c_master_byte_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   i2cseq_step_checker #(
      .TargetCsrOffset (TargetCsrOffset)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_chan),
      .rsp_mon           (rsp_chan),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .pready            (pready),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .error_count       (error_count),
      .outstanding_steps (outstanding_steps)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   task automatic send_tick(input logic [2:0] op, input logic [7:0] data, input logic dir,
                            input logic last, input logic sda);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.data_byte <= data;
      req_chan.read_direction <= dir;
      req_chan.last_read <= last;
      req_chan.sda_in <= sda;
      do @(posedge clock); while (!req_chan.ready);
      ticks_sent++;
      @(negedge clock);
   endtask

   function automatic int unsigned command_ticks(input logic [2:0] op);
      case (op)
         OP_START: return StartTicks;
         OP_WRITE, OP_READ: return ByteTicks;
         OP_STOP: return StopTicks;
         default: return 1;
      endcase
   endfunction

   // The line level follows the wanted bit for the three ticks of each bit slot, then holds
   // the acknowledge level; a start spends its first two ticks on the start condition.
   task automatic run_command(input logic [2:0] op, input logic [7:0] data, input logic dir,
                              input logic last, input logic [7:0] rx_bits, input logic ack,
                              input int unsigned intrude_pct);
      int total;
      int lead;
      logic [2:0] tick_op;
      logic sda;
      total = command_ticks(op);
      lead = (op == OP_START) ? 2 : 0;
      for (int t = 0; t < total; t++) begin
         sda = (t >= lead && t - lead < 24) ? rx_bits[7 - (t - lead) / 3] : ack;
         if (t == 0) begin
            send_tick(op, data, dir, last, sda);
         end else begin
            tick_op = OP_NONE;
            if ($urandom_range(99) < intrude_pct) tick_op = 3'($urandom_range(7));
            send_tick(tick_op, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), sda);
         end
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (outstanding_steps != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CsrAddrWidth-1:0] addr,
                             input logic [CsrDataWidth-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_transaction();
      int unsigned intrude_pct;
      intrude_pct = ($urandom_range(3) == 0) ? 5 : 0;
      run_command(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 8'($urandom_range(255)), $urandom_range(3) == 0,
                  intrude_pct);
      repeat ($urandom_range(4)) begin
         run_command($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom_range(255)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                     $urandom_range(3) == 0, intrude_pct);
      end
      if ($urandom_range(9) < 7) begin
         run_command(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                     intrude_pct);
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(6, 1)) begin
         send_tick(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      repeat (StartTicks) begin
         send_tick(OP_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      int unsigned phase_start;
      logic [CsrDataWidth-1:0] target_value;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_NONE;
      req_chan.data_byte = '0;
      req_chan.read_direction = 1'b0;
      req_chan.last_read = 1'b0;
      req_chan.sda_in = 1'b1;
      rsp_chan.ready = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      ticks_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_access(1'b0, TargetCsrOffset, '0);
      run_command(OP_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 0);
      for (int c = OP_STOP + 1; c < 8; c++) begin
         send_tick(3'(c), 8'hFF, 1'b1, 1'b1, 1'b0);
      end
      send_tick(OP_NONE, 8'h00, 1'b0, 1'b0, 1'b1);
      run_command(OP_START, 8'h00, 1'b0, 1'b0, 8'hFF, 1'b0, 0);
      run_command(OP_WRITE, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 0);
      run_command(OP_WRITE, 8'h00, 1'b0, 1'b0, 8'hFF, 1'b1, 0);
      run_command(OP_READ, 8'h00, 1'b0, 1'b0, 8'hFF, 1'b1, 0);
      run_command(OP_READ, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 0);
      run_command(OP_READ, 8'h5A, 1'b0, 1'b0, 8'hA5, 1'b0, 100);
      run_command(OP_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 100);

      drain();
      csr_access(1'b1, SpareCsrOffset, 32'hFFFF_FFFF);
      csr_access(1'b0, TargetCsrOffset, '0);
      csr_access(1'b1, TargetCsrOffset, '0);
      run_command(OP_START, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 0);
      run_command(OP_STOP, 8'h00, 1'b0, 1'b0, 8'hFF, 1'b1, 0);
      drain();
      csr_access(1'b1, TargetCsrOffset, 32'hFFFF_FFFF);
      csr_access(1'b0, TargetCsrOffset, '0);
      run_command(OP_START, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 0);
      run_command(OP_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 0);

      for (int p = 0; p < 4; p++) begin
         drain();
         case (p)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
               target_value = $urandom;
            end
            1: begin
               send_idle_pct = 74;
               stall_pct = 0;
               target_value = '0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 74;
               target_value = 32'h7F;
            end
            default: begin
               send_idle_pct = 35;
               stall_pct = 35;
               target_value = $urandom_range(127);
            end
         endcase
         csr_access(1'b1, TargetCsrOffset, target_value);
         csr_access(1'b0, TargetCsrOffset, '0);
         phase_start = ticks_sent;
         while (ticks_sent - phase_start < PhaseItems) begin
            if ($urandom_range(99) < 85) random_transaction();
            else noise_burst();
            if ($urandom_range(49) == 0) drain();
         end
      end

      drain();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
